@@ hdl/undirected_graph_reachability_macros.svh @@
// Assertion macros shared by the graph reachability RTL.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef UNDIRECTED_GRAPH_REACHABILITY_MACROS_SVH
`define UNDIRECTED_GRAPH_REACHABILITY_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define UGR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ugr_pkg.sv @@
// Shared types and constants for the graph reachability block.
// Used by the RTL modules and the testbench; depends on nothing else.
package ugr_pkg;

    localparam int NODE_W = 6;

    // Item function codes.
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_REJECT  = 2'd0;
    localparam logic [1:0] ST_ADDED   = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_QUERY   = 2'd3;

    // Command from the sequencer to the search engine.
    typedef struct packed {
        logic              start;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } ugr_srch_cmd_t;

    // Status and row-read request from the search engine.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic              rd_en;
        logic [NODE_W-1:0] rd_node;
        logic              reach;
    } ugr_srch_sts_t;

endpackage

@@ hdl/undirected_graph_reachability.sv @@
// Undirected graph reachability block.
// Input channel: func, node_a, node_b with in_valid / in_stall; a beat is taken
// when in_valid is high and in_stall is low. func 0 adds edge node_a-node_b,
// func 1 asks whether node_b is reachable from node_a.
// Output channel: status, reachable, degree_a, degree_b with out_valid /
// out_stall; one result beat per input beat, in order.
// Adjacency rows sit in one synchronous RAM, one row per node; a valid bit per
// row makes a never-written row read as empty.
// An add passes through S_RDB, S_CHK, S_WB and S_DONE; a query runs the search
// in S_SRCH first and then takes the same path. A query with node_a equal to
// node_b, or naming a node that does not exist, starts the search with an empty
// frontier. Otherwise the search issues one RAM row read per cycle while its
// frontier holds a node, and waits whenever the frontier runs empty while a row
// read is still landing.
// One item is in flight at a time; in_stall stays high until its result has
// been loaded into the output register, which holds it while out_stall is high.
// Reset clears the whole graph at once through the row valid bits; no
// clearing pass is needed and the block accepts beats right after reset.
`include "undirected_graph_reachability_macros.svh"

module undirected_graph_reachability
    import ugr_pkg::*;
#(
    parameter int NODES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic              reachable,
    output logic [5:0]        degree_a,
    output logic [5:0]        degree_b
);

    // Node fields are six bits wide, so only the first 64 nodes can hold edges.
    localparam int ROW_W = (NODES < 64) ? NODES : 64;
    localparam int AW    = $clog2(ROW_W);
    localparam int NG    = (ROW_W + 7) / 8;
    localparam int PAD_W = NG * 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  row_valid_reg, row_valid_next;
    logic              rd_vld_reg;

    logic              func_reg, func_next;
    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic              reach_reg, reach_next;
    logic [1:0]        st_reg, st_next;
    logic [ROW_W-1:0]  row_a_reg, row_a_next;
    logic [ROW_W-1:0]  row_b_reg, row_b_next;
    logic              wr_b_reg, wr_b_next;
    logic [3:0]        part_a_reg [NG];
    logic [3:0]        part_a_next [NG];
    logic [3:0]        part_b_reg [NG];
    logic [3:0]        part_b_next [NG];
    logic [1:0]        status_reg, status_next;
    logic              reachable_reg, reachable_next;
    logic [5:0]        degree_a_reg, degree_a_next;
    logic [5:0]        degree_b_reg, degree_b_next;

    logic              accept;
    logic              a_ok, b_ok;
    logic [ROW_W-1:0]  row_q;
    logic [ROW_W-1:0]  row_b_cur;
    logic [ROW_W-1:0]  bit_a, bit_b;
    logic              do_add;
    logic [PAD_W-1:0]  pad_a, pad_b;
    logic [6:0]        sum_a, sum_b;
    logic              load_out;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic [AW-1:0]     rd_addr;
    logic [ROW_W-1:0]  rd_data;

    ugr_srch_cmd_t     cmd;
    ugr_srch_sts_t     sts;

    ugr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_W)
    ) u_adj (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ugr_search #(
        .ROW_W (ROW_W)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .row   (row_q),
        .sts   (sts)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign a_ok  = {1'b0, a_reg} < (NODE_W+1)'(ROW_W);
    assign b_ok  = {1'b0, b_reg} < (NODE_W+1)'(ROW_W);
    assign bit_a = ROW_W'(1) << a_reg[AW-1:0];
    assign bit_b = ROW_W'(1) << b_reg[AW-1:0];

    // A row that was never written reads as empty.
    assign row_q     = rd_vld_reg ? rd_data : '0;
    assign row_b_cur = b_ok ? row_q : '0;
    assign do_add    = (func_reg == FUNC_ADD) && a_ok && b_ok && (a_reg != b_reg)
                     && !row_a_reg[b_reg[AW-1:0]];

    assign pad_a = PAD_W'(row_a_reg);
    assign pad_b = PAD_W'(row_b_reg);

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cmd.start = accept && (func == FUNC_QUERY);
        cmd.src   = node_a;
        cmd.dst   = node_b;
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = node_a[AW-1:0];
            S_SRCH:  rd_addr = sts.rd_en ? sts.rd_node[AW-1:0] : a_reg[AW-1:0];
            S_RDB:   rd_addr = b_reg[AW-1:0];
            default: rd_addr = b_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = a_reg[AW-1:0];
        wr_data = row_a_next;
        if (state_reg == S_CHK)
        begin
            wr_en = do_add;
        end
        else if (state_reg == S_WB)
        begin
            wr_en   = wr_b_reg;
            wr_addr = b_reg[AW-1:0];
            wr_data = row_b_reg;
        end
    end

    always_comb
    begin
        sum_a = '0;
        sum_b = '0;
        for (int g = 0; g < NG; g++)
        begin
            sum_a = sum_a + 7'(part_a_reg[g]);
            sum_b = sum_b + 7'(part_b_reg[g]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        row_valid_next = row_valid_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        reach_next     = reach_reg;
        st_next        = st_reg;
        row_a_next     = row_a_reg;
        row_b_next     = row_b_reg;
        wr_b_next      = wr_b_reg;
        part_a_next    = part_a_reg;
        part_b_next    = part_b_reg;
        status_next    = status_reg;
        reachable_next = reachable_reg;
        degree_a_next  = degree_a_reg;
        degree_b_next  = degree_b_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    a_next     = node_a;
                    b_next     = node_b;
                    reach_next = 1'b0;
                    state_next = (func == FUNC_QUERY) ? S_SRCH : S_RDB;
                end
            end
            S_SRCH:
            begin
                if (sts.done)
                begin
                    reach_next = sts.reach;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                row_a_next = a_ok ? row_q : '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                row_b_next = row_b_cur;
                wr_b_next  = do_add;
                if (func_reg == FUNC_QUERY)
                begin
                    st_next = ST_QUERY;
                end
                else if (!a_ok || !b_ok || (a_reg == b_reg))
                begin
                    st_next = ST_REJECT;
                end
                else if (row_a_reg[b_reg[AW-1:0]])
                begin
                    st_next = ST_PRESENT;
                end
                else
                begin
                    st_next    = ST_ADDED;
                    row_a_next = row_a_reg | bit_b;
                    row_b_next = row_b_cur | bit_a;
                    row_valid_next[a_reg[AW-1:0]] = 1'b1;
                    row_valid_next[b_reg[AW-1:0]] = 1'b1;
                end
                state_next = S_WB;
            end
            S_WB:
            begin
                // First level of the degree count: one partial sum per byte.
                for (int g = 0; g < NG; g++)
                begin
                    part_a_next[g] = '0;
                    part_b_next[g] = '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        part_a_next[g] = part_a_next[g] + 4'(pad_a[g*8+i]);
                        part_b_next[g] = part_b_next[g] + 4'(pad_b[g*8+i]);
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    reachable_next = reach_reg;
                    degree_a_next  = sum_a[5:0];
                    degree_b_next  = sum_b[5:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
            rd_vld_reg    <= row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        reach_reg     <= reach_next;
        st_reg        <= st_next;
        row_a_reg     <= row_a_next;
        row_b_reg     <= row_b_next;
        wr_b_reg      <= wr_b_next;
        part_a_reg    <= part_a_next;
        part_b_reg    <= part_b_next;
        status_reg    <= status_next;
        reachable_reg <= reachable_next;
        degree_a_reg  <= degree_a_next;
        degree_b_reg  <= degree_b_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign reachable = reachable_reg;
    assign degree_a  = degree_a_reg;
    assign degree_b  = degree_b_reg;

    `UGR_ASSERT_NOW(a_write_state, wr_en, (state_reg == S_CHK) || (state_reg == S_WB),
        "row write outside the update states")
    `UGR_ASSERT_NOW(a_search_state, sts.busy, state_reg == S_SRCH,
        "search running outside the search state")
    `UGR_ASSERT_NOW(a_result_source, $rose(out_valid_reg), $past(state_reg == S_DONE),
        "result appeared without a finished item")
    `UGR_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE,
        "accepted beat did not start work")

endmodule

@@ hdl/ugr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ugr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ugr_search.sv @@
// Reachability search engine: visited and frontier masks, one row expansion per cycle while a node is pending.
// Depends on ugr_pkg and undirected_graph_reachability_macros.svh.
`include "undirected_graph_reachability_macros.svh"

module ugr_search
    import ugr_pkg::*;
#(
    parameter int ROW_W = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ugr_srch_cmd_t cmd,
    input  logic [ROW_W-1:0] row,
    output ugr_srch_sts_t sts
);

    localparam int AW = $clog2(ROW_W);

    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [ROW_W-1:0] visited_reg, visited_next;
    logic [ROW_W-1:0] frontier_reg, frontier_next;
    logic [AW-1:0]    dst_reg, dst_next;
    logic             same_reg, same_next;

    logic             src_ok, dst_ok;
    logic [ROW_W-1:0] seed;
    logic [ROW_W-1:0] low;
    logic [ROW_W-1:0] fresh;
    logic [AW-1:0]    pop_idx;
    logic             done;

    assign src_ok = {1'b0, cmd.src} < (NODE_W+1)'(ROW_W);
    assign dst_ok = {1'b0, cmd.dst} < (NODE_W+1)'(ROW_W);
    assign seed   = (src_ok && dst_ok && (cmd.src != cmd.dst))
                  ? (ROW_W'(1) << cmd.src[AW-1:0]) : '0;

    // Lowest pending node; the order of expansion does not change the final set.
    assign low   = frontier_reg & (~frontier_reg + ROW_W'(1));
    assign fresh = pend_reg ? (row & ~visited_reg) : '0;
    assign done  = busy_reg && !pend_reg && (frontier_reg == '0);

    always_comb
    begin
        pop_idx = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (low[i])
            begin
                pop_idx = pop_idx | AW'(i);
            end
        end
    end

    always_comb
    begin
        busy_next     = busy_reg;
        pend_next     = pend_reg;
        visited_next  = visited_reg;
        frontier_next = frontier_reg;
        dst_next      = dst_reg;
        same_next     = same_reg;
        if (cmd.start)
        begin
            busy_next     = 1'b1;
            pend_next     = 1'b0;
            visited_next  = seed;
            frontier_next = seed;
            dst_next      = cmd.dst[AW-1:0];
            same_next     = (cmd.src == cmd.dst);
        end
        else if (busy_reg)
        begin
            // A row read issued last cycle lands now while the next one is issued.
            visited_next  = visited_reg | fresh;
            frontier_next = (frontier_reg & ~low) | fresh;
            pend_next     = |frontier_reg;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            visited_reg  <= '0;
            frontier_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pend_reg     <= pend_next;
            visited_reg  <= visited_next;
            frontier_reg <= frontier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg  <= dst_next;
        same_reg <= same_next;
    end

    always_comb
    begin
        sts.busy    = busy_reg;
        sts.done    = done;
        sts.rd_en   = busy_reg && (|frontier_reg);
        sts.rd_node = NODE_W'(pop_idx);
        sts.reach   = same_reg || visited_reg[dst_reg];
    end

    `UGR_ASSERT_NOW(a_frontier_visited, busy_reg, (frontier_reg & ~visited_reg) == '0,
        "frontier holds a node that is not visited")
    `UGR_ASSERT_NOW(a_pend_busy, pend_reg, busy_reg, "row read pending outside a search")
    `UGR_ASSERT_NEXT(a_start_busy, cmd.start, busy_reg, "search did not start")

endmodule

@@ tb/undirected_graph_reachability_tb.sv @@
// Self-checking testbench for the undirected graph reachability block.
// It depends only on the block's RTL (ugr_pkg and the top level) and keeps its
// own copy of the adjacency matrix to predict every result beat.
`timescale 1ns / 100ps

module undirected_graph_reachability_tb
    import ugr_pkg::*;
();

    localparam int NODE_COUNT     = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [1:0] status;
        logic       reachable;
        logic [5:0] degree_a;
        logic [5:0] degree_b;
    } graph_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              func = 1'b0;
    logic [NODE_W-1:0] node_a = '0;
    logic [NODE_W-1:0] node_b = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic              reachable;
    logic [5:0]        degree_a;
    logic [5:0]        degree_b;

    logic [NODE_COUNT-1:0] adj_rows [NODE_COUNT];
    graph_result_t         pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int n_added        = 0;
    int n_present      = 0;
    int n_rejected     = 0;
    int n_queries      = 0;
    int n_reached      = 0;

    undirected_graph_reachability #(
        .NODES(NODE_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .reachable (reachable),
        .degree_a  (degree_a),
        .degree_b  (degree_b)
    );

    always #5 clk = ~clk;

    // Applies one item to the local graph and returns the result it must produce.
    function automatic graph_result_t predict_step(logic fn, logic [5:0] a,
                                                   logic [5:0] b);
        graph_result_t         res;
        logic [NODE_COUNT-1:0] seen;
        logic [NODE_COUNT-1:0] frontier;
        logic [NODE_COUNT-1:0] fresh;
        int                    node;
        res = '0;
        if (fn == FUNC_ADD)
        begin
            if (a == b)
            begin
                res.status = ST_REJECT;
            end
            else if (adj_rows[a][b])
            begin
                res.status = ST_PRESENT;
            end
            else
            begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                res.status = ST_ADDED;
            end
        end
        else
        begin
            res.status = ST_QUERY;
            if (a == b)
            begin
                res.reachable = 1'b1;
            end
            else
            begin
                seen = '0;
                seen[a] = 1'b1;
                frontier = seen;
                // Expand the lowest pending node each step, as the block does.
                for (int step = 0; step < NODE_COUNT && frontier != '0; step++)
                begin
                    node = 0;
                    while (!frontier[node])
                        node++;
                    frontier[node] = 1'b0;
                    fresh = adj_rows[node] & ~seen;
                    seen = seen | fresh;
                    frontier = frontier | fresh;
                end
                res.reachable = seen[b];
            end
        end
        res.degree_a = 6'($countones(adj_rows[a]));
        res.degree_b = 6'($countones(adj_rows[b]));
        return res;
    endfunction

    // Random node in the same residue class mod 3 as the given node. Random adds
    // stay inside these classes, so random adds alone never collapse the graph into one component.
    function automatic logic [5:0] same_class_node(logic [5:0] a);
        logic [5:0] b;
        b = 6'($urandom_range(NODE_COUNT - 1));
        while ((b % 3) != (a % 3))
            b = 6'($urandom_range(NODE_COUNT - 1));
        return b;
    endfunction

    // Presents one beat, waits for it to be taken and records the expected result.
    task automatic send_item(logic fn, logic [5:0] a, logic [5:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        node_a   <= a;
        node_b   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_step(fn, a, b));
    endtask

    // Self-loops, duplicate adds, the extreme indices and short chains.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(FUNC_QUERY, 6'd0, 6'd0);
        send_item(FUNC_QUERY, 6'd0, 6'd63);
        send_item(FUNC_ADD, 6'd0, 6'd0);
        send_item(FUNC_ADD, 6'd63, 6'd63);
        send_item(FUNC_ADD, 6'd0, 6'd63);
        send_item(FUNC_ADD, 6'd63, 6'd0);
        send_item(FUNC_ADD, 6'd0, 6'd63);
        send_item(FUNC_QUERY, 6'd63, 6'd0);
        send_item(FUNC_ADD, 6'd3, 6'd60);
        send_item(FUNC_ADD, 6'd60, 6'd30);
        send_item(FUNC_ADD, 6'd30, 6'd33);
        send_item(FUNC_QUERY, 6'd3, 6'd33);
        send_item(FUNC_QUERY, 6'd33, 6'd3);
        send_item(FUNC_QUERY, 6'd0, 6'd33);
        send_item(FUNC_QUERY, 6'd30, 6'd30);
        send_item(FUNC_ADD, 6'd33, 6'd33);
        send_item(FUNC_ADD, 6'd33, 6'd0);
        send_item(FUNC_QUERY, 6'd63, 6'd3);
        send_item(FUNC_QUERY, 6'd3, 6'd63);
        send_item(FUNC_QUERY, 6'd63, 6'd1);
    endtask

    // Mostly well-formed traffic: chain-building adds and queries, plus noise.
    task automatic test_random(int idle_pct, int stall_pct, int count);
        logic [5:0] a;
        logic [5:0] b;
        int         roll;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            a    = 6'($urandom_range(NODE_COUNT - 1));
            roll = $urandom_range(99);
            if (roll < 5)
            begin
                send_item(FUNC_ADD, a, a);
            end
            else if (roll < 10)
            begin
                send_item(FUNC_QUERY, a, 6'($urandom_range(NODE_COUNT - 1)));
            end
            else if (roll < 35)
            begin
                // Steps of three build long paths for the search to walk.
                if ($urandom_range(1))
                    b = (a <= 6'd60) ? a + 6'd3 : a - 6'd3;
                else
                    b = same_class_node(a);
                send_item(FUNC_ADD, a, b);
            end
            else
            begin
                if ($urandom_range(1))
                    b = same_class_node(a);
                else
                    b = 6'($urandom_range(NODE_COUNT - 1));
                send_item(FUNC_QUERY, a, b);
            end
        end
    endtask

    // Connects node 63 to every other node, giving it the largest degree.
    task automatic test_dense_graph();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int x = 0; x < NODE_COUNT - 1; x++)
            send_item(FUNC_ADD, 6'd63, 6'(x));
        for (int i = 0; i < 20; i++)
            send_item(FUNC_QUERY, 6'($urandom_range(NODE_COUNT - 1)),
                      6'($urandom_range(NODE_COUNT - 1)));
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        graph_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no item outstanding: status %0d", status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (reachable !== want.reachable)
                begin
                    $error("reachable: expected %0d, got %0d", want.reachable, reachable);
                    error_count++;
                end
                if (degree_a !== want.degree_a)
                begin
                    $error("degree_a: expected %0d, got %0d", want.degree_a, degree_a);
                    error_count++;
                end
                if (degree_b !== want.degree_b)
                begin
                    $error("degree_b: expected %0d, got %0d", want.degree_b, degree_b);
                    error_count++;
                end
                case (want.status)
                    ST_ADDED:   n_added++;
                    ST_PRESENT: n_present++;
                    ST_REJECT:  n_rejected++;
                    default:
                    begin
                        n_queries++;
                        if (want.reachable)
                            n_reached++;
                    end
                endcase
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        foreach (adj_rows[i])
            adj_rows[i] = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(0, 0, 480);
        test_random(77, 0, 480);
        test_random(0, 77, 480);
        test_random(15, 15, 480);
        test_dense_graph();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end

        $display("Covered %0d adds (%0d new, %0d duplicate, %0d rejected) and %0d queries,",
                 n_added + n_present + n_rejected, n_added, n_present, n_rejected,
                 n_queries);
        $display("%0d of them reachable, under four sender/receiver idling profiles.",
                 n_reached);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
